### hw/rtl/integer_gcd_lcm_unit_core_assert.svh
// Assertion macros shared by the gcd/lcm unit RTL.
`ifndef INTEGER_GCD_LCM_UNIT_CORE_ASSERT_SVH
`define INTEGER_GCD_LCM_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define IGL_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gcd/lcm unit: assertion failed");

// next-cycle implication
`define IGL_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcd/lcm unit: assertion failed");

`endif

### hw/rtl/igl_pkg.sv
// Package of the gcd/lcm unit: operation codes, widths and divider status type.
package igl_pkg;

	localparam int unsigned DEF_WIDTH = 32;
	localparam int unsigned FIELD_W   = 32;

	localparam logic [1:0] FUNC_GCD  = 2'd0;
	localparam logic [1:0] FUNC_LCM  = 2'd1;
	localparam logic [1:0] FUNC_XGCD = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### hw/rtl/igl_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module igl_div #(
	parameter int unsigned WIDTH = igl_pkg::DEF_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WIDTH-1:0]    dividend,
	input  logic [WIDTH-1:0]    divisor,
	output logic [WIDTH-1:0]    quotient,
	output logic [WIDTH-1:0]    remainder,
	output igl_pkg::div_stat_t  stat
);

	localparam int unsigned CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   rem_shift;
	logic             fits;

	assign rem_shift = {rem_q, quo_q[WIDTH-1]};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDTH-2:0], fits};
			if (fits) begin
				rem_q <= WIDTH'(rem_shift - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_shift[WIDTH-1:0];
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat      = '{busy: busy_q, done: done_q};

endmodule

### hw/rtl/integer_gcd_lcm_unit_core.sv
// Top level of the gcd / lcm / extended gcd unit.
// One transaction at a time; each Euclid step is one pass of the shared divider.
// Extended gcd steps add the MS, US and UT coefficient updates; lcm adds a division of the
// first operand by the gcd (LDIV) and a multiply (LMUL). At most about 48 steps for 32 bits;
// s_axis_tready returns in the same cycle as m_axis_tvalid, as the result register loads.
// Reset (arst_n low, asynchronous) empties the sequencer and clears the output valid.
module integer_gcd_lcm_unit_core #(
	parameter int unsigned WIDTH = igl_pkg::DEF_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // first_value[31:0], second_value[63:32]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // value[31:0], coeff_first[63:32], coeff_second[95:64]
	output logic        m_axis_tuser   // error
);

	localparam int unsigned FW = igl_pkg::FIELD_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_MS    = 4'd3;
	localparam logic [3:0] ST_US    = 4'd4;
	localparam logic [3:0] ST_UT    = 4'd5;
	localparam logic [3:0] ST_LDIV  = 4'd6;
	localparam logic [3:0] ST_LMUL  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	localparam logic [WIDTH-1:0] SIGN_MIN = {1'b1, {(WIDTH-1){1'b0}}};

	logic [3:0]       state_q;
	logic [1:0]       func_q;
	logic [WIDTH-1:0] ua_q, ub_q;
	logic [WIDTH-1:0] a_q, b_q;
	logic [WIDTH-1:0] s0_q, s1_q, t0_q, t1_q;
	logic [WIDTH-1:0] q_q, prod_q;
	logic [FW-1:0]    res_q, x_q, y_q;
	logic             err_q;
	logic             m_valid_q;
	logic [95:0]      m_data_q;
	logic             m_err_q;

	logic             in_acc;
	logic             out_free;
	logic [1:0]       in_func;
	logic [WIDTH-1:0] in_a, in_b;
	logic             xg;
	logic             a_neg, b_neg;
	logic [WIDTH-1:0] a_mag, b_mag;
	logic             div_start;
	logic [WIDTH-1:0] div_dividend, div_divisor;
	logic [WIDTH-1:0] div_quo, div_rem;
	igl_pkg::div_stat_t div_stat;
	logic [WIDTH-1:0] quo_s, rem_s;
	logic [WIDTH-1:0] mul_y;
	logic [2*WIDTH-1:0] mul_full;
	logic [WIDTH-1:0] mul_lo;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign in_func       = s_axis_tuser;
	assign in_a          = s_axis_tdata[WIDTH-1:0];
	assign in_b          = s_axis_tdata[32+WIDTH-1:32];

	assign xg    = (func_q == igl_pkg::FUNC_XGCD);
	assign a_neg = xg && a_q[WIDTH-1];
	assign b_neg = xg && b_q[WIDTH-1];
	assign a_mag = a_neg ? WIDTH'(WIDTH'(0) - a_q) : a_q;
	assign b_mag = b_neg ? WIDTH'(WIDTH'(0) - b_q) : b_q;

	// b == 0 in CHECK with lcm: divide the first operand by the gcd
	assign div_start    = (state_q == ST_CHECK) &&
		((b_q != '0) || (func_q == igl_pkg::FUNC_LCM && a_q != '0));
	assign div_dividend = (b_q == '0) ? ua_q : a_mag;
	assign div_divisor  = (b_q == '0) ? a_q : b_mag;

	igl_div #(.WIDTH(WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	assign quo_s = (a_neg ^ b_neg) ? WIDTH'(WIDTH'(0) - div_quo) : div_quo;
	assign rem_s = a_neg ? WIDTH'(WIDTH'(0) - div_rem) : div_rem;

	always_comb begin
		unique case (state_q)
			ST_MS:   mul_y = s1_q;
			ST_US:   mul_y = t1_q;
			default: mul_y = ub_q;
		endcase
	end

	assign mul_full = (2*WIDTH)'(q_q) * (2*WIDTH)'(mul_y);
	assign mul_lo   = mul_full[WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_func == igl_pkg::FUNC_GCD || in_func == igl_pkg::FUNC_LCM) begin
							state_q <= ST_CHECK;
						end else if (in_func == igl_pkg::FUNC_XGCD &&
							in_a != SIGN_MIN && in_b != SIGN_MIN) begin
							state_q <= ST_CHECK;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_CHECK: begin
					if (b_q != '0) begin
						state_q <= ST_DIV;
					end else if (div_start) begin
						state_q <= ST_LDIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= xg ? ST_MS : ST_CHECK;
					end
				end
				ST_MS:   state_q <= ST_US;
				ST_US:   state_q <= ST_UT;
				ST_UT:   state_q <= ST_CHECK;
				ST_LDIV: begin
					if (div_stat.done) begin
						state_q <= ST_LMUL;
					end
				end
				ST_LMUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q <= in_func;
				ua_q   <= in_a;
				ub_q   <= in_b;
				a_q    <= in_a;
				b_q    <= in_b;
				s0_q   <= WIDTH'(1);
				s1_q   <= '0;
				t0_q   <= '0;
				t1_q   <= WIDTH'(1);
				res_q  <= '0;
				x_q    <= '0;
				y_q    <= '0;
				err_q  <= (in_func != igl_pkg::FUNC_GCD && in_func != igl_pkg::FUNC_LCM &&
					in_func != igl_pkg::FUNC_XGCD) ||
					(in_func == igl_pkg::FUNC_XGCD && (in_a == SIGN_MIN || in_b == SIGN_MIN));
			end
			ST_CHECK: begin
				if (b_q == '0) begin
					if (func_q == igl_pkg::FUNC_GCD) begin
						res_q <= FW'(a_q);
					end else if (func_q == igl_pkg::FUNC_LCM) begin
						err_q <= (a_q == '0);
					end else begin
						res_q <= FW'(signed'(a_q));
						x_q   <= FW'(signed'(s0_q));
						y_q   <= FW'(signed'(t0_q));
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					a_q <= b_q;
					b_q <= rem_s;
					q_q <= quo_s;
				end
			end
			ST_MS: prod_q <= mul_lo;
			ST_US: begin
				s0_q   <= s1_q;
				s1_q   <= WIDTH'(s0_q - prod_q);
				prod_q <= mul_lo;
			end
			ST_UT: begin
				t0_q <= t1_q;
				t1_q <= WIDTH'(t0_q - prod_q);
			end
			ST_LDIV: begin
				if (div_stat.done) begin
					q_q <= div_quo;
				end
			end
			ST_LMUL: res_q <= FW'(mul_lo);
			ST_OUT: begin
				if (out_free) begin
					m_data_q <= {y_q, x_q, res_q};
					m_err_q  <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_err_q;

`include "integer_gcd_lcm_unit_core_assert.svh"

	`IGL_ASSERT_IMP(a_div_nonzero, div_start, div_divisor != '0)
	`IGL_ASSERT_IMP(a_div_owner, div_stat.busy || div_stat.done, state_q == ST_DIV || state_q == ST_LDIV)
	`IGL_ASSERT_NXT(a_out_load, state_q == ST_OUT && out_free, m_axis_tvalid && state_q == ST_IDLE)

endmodule

### dv/integer_gcd_lcm_unit_core_tb.sv
// Testbench for integer_gcd_lcm_unit_core: directed cases and random stream traffic against a gcd/lcm/xgcd predictor.
module integer_gcd_lcm_unit_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_RSVD   = 2'd3;
	localparam int         IDLE_PCT    = 36;
	localparam int         HOLD_AT     = 200;
	localparam int         HOLD_CYCLES = 6000;
	localparam int         CHUNK_ITEMS = 109;
	localparam int         MAX_QUOTS   = 128;
	localparam int         TAIL_CYCLES = 2000;
	localparam longint     CYCLE_LIMIT = 5_000_000;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] a;
		logic [31:0] b;
	} gcd_op_t;

	typedef struct packed {
		logic        [31:0] value;
		logic signed [31:0] coeff_first;
		logic signed [31:0] coeff_second;
		logic               error;
	} gcd_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;

	gcd_op_t  pending_ops[$];
	gcd_res_t expected_results[$];
	gcd_op_t  in_flight_op;
	int       accepted_count = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;
	int       mismatch_count = 0;
	int       error_count = 0;
	longint   cycle_count = 0;
	logic     calm;

	integer_gcd_lcm_unit_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// no idling on either side for a stretch of transactions
	assign calm = (accepted_count >= 60) && (accepted_count < 120);

	function automatic longint unsigned euclid_gcd(input longint unsigned x,
			input longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic longint wrap32(input longint v);
		logic signed [31:0] w;
		w = v[31:0];
		return w;
	endfunction

	function automatic gcd_res_t compute_result(input gcd_op_t op);
		gcd_res_t        r;
		longint unsigned g, p;
		longint          sa, sb, rem, x, y, t;
		longint          quots[$];
		r = '0;
		case (op.func)
			igl_pkg::FUNC_GCD: begin
				g = euclid_gcd(op.a, op.b);
				r.value = g[31:0];
			end
			igl_pkg::FUNC_LCM: begin
				g = euclid_gcd(op.a, op.b);
				if (g == 0) begin
					r.error = 1'b1;
				end else begin
					p = (longint'(op.a) * longint'(op.b)) / g;
					r.value = p[31:0];
				end
			end
			igl_pkg::FUNC_XGCD: begin
				if (op.a == 32'h8000_0000 || op.b == 32'h8000_0000) begin
					r.error = 1'b1;
				end else begin
					sa = wrap32(longint'(op.a));
					sb = wrap32(longint'(op.b));
					while (sb != 0 && quots.size() < MAX_QUOTS) begin
						rem = sa % sb;
						quots.insert(quots.size(), sa / sb);
						sa = sb;
						sb = rem;
					end
					x = 1;
					y = 0;
					for (int i = quots.size() - 1; i >= 0; i--) begin
						t = y;
						y = wrap32(x - quots[i] * y);
						x = wrap32(t);
					end
					r.value = sa[31:0];
					r.coeff_first = x[31:0];
					r.coeff_second = y[31:0];
				end
			end
			default: r.error = 1'b1;
		endcase
		return r;
	endfunction

	task automatic add_op(input logic [1:0] func, input logic [31:0] a, input logic [31:0] b);
		gcd_op_t op;
		op.func = func;
		op.a = a;
		op.b = b;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	function automatic logic [31:0] rand_operand();
		logic [31:0] specials[6] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0001, 32'hFFFF_FFFF};
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4: return $urandom_range(1000);
			5: return -$urandom_range(1000);
			6: return $urandom >> $urandom_range(31);
			7: return specials[$urandom_range(5)];
			default: return $urandom_range(65535);
		endcase
	endfunction

	task automatic add_random_op();
		logic [1:0]  func;
		logic [31:0] a, b, g;
		func = ($urandom_range(99) < 5) ? FUNC_RSVD : 2'($urandom_range(2));
		a = rand_operand();
		b = rand_operand();
		case ($urandom_range(9))
			0, 1: begin
				g = $urandom_range(1, 65535);
				a = g * $urandom_range(65535);
				b = g * $urandom_range(65535);
				if ($urandom_range(1))
					a = -a;
			end
			2: b = a;
			3: if ($urandom_range(1)) a = '0; else b = '0;
			default: ;
		endcase
		add_op(func, a, b);
	endtask

	function automatic logic all_done();
		return pending_ops.size() == 0 && !s_axis_tvalid && expected_results.size() == 0;
	endfunction

	task automatic wait_drained();
		do @(negedge clk); while (!all_done());
	endtask

	task automatic check_result(input gcd_res_t got);
		gcd_res_t exp;
		if (expected_results.size() == 0) begin
			error_count++;
			$display("unexpected result transaction: value=%h err=%b", got.value, got.error);
			return;
		end
		exp = expected_results.pop_front();
		if (got.value !== exp.value || got.coeff_first !== exp.coeff_first ||
				got.coeff_second !== exp.coeff_second || got.error !== exp.error) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch: exp value=%h x=%h y=%h err=%b, got value=%h x=%h y=%h err=%b",
					exp.value, exp.coeff_first, exp.coeff_second, exp.error,
					got.value, got.coeff_first, got.coeff_second, got.error);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.insert(expected_results.size(), compute_result(in_flight_op));
				accepted_count <= accepted_count + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					in_flight_op = pending_ops.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {in_flight_op.b, in_flight_op.a};
					s_axis_tuser <= in_flight_op.func;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the unit backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_count == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result({m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
					m_axis_tuser});
			m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_op(igl_pkg::FUNC_GCD, 32'd0, 32'd0);
		add_op(igl_pkg::FUNC_GCD, 32'd12345, 32'd0);
		add_op(igl_pkg::FUNC_GCD, 32'd0, 32'hFFFF_FFFF);
		add_op(igl_pkg::FUNC_GCD, 32'd12, 32'd18);
		add_op(igl_pkg::FUNC_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		add_op(igl_pkg::FUNC_GCD, 32'd2971215073, 32'd1836311903);
		add_op(igl_pkg::FUNC_LCM, 32'd0, 32'd0);
		add_op(igl_pkg::FUNC_LCM, 32'd0, 32'd5);
		add_op(igl_pkg::FUNC_LCM, 32'd7, 32'd0);
		add_op(igl_pkg::FUNC_LCM, 32'd4, 32'd6);
		add_op(igl_pkg::FUNC_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		add_op(igl_pkg::FUNC_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_op(igl_pkg::FUNC_XGCD, 32'h8000_0000, 32'd5);
		add_op(igl_pkg::FUNC_XGCD, 32'd5, 32'h8000_0000);
		add_op(igl_pkg::FUNC_XGCD, -32'sd7, 32'd0);
		add_op(igl_pkg::FUNC_XGCD, 32'd0, 32'd0);
		add_op(igl_pkg::FUNC_XGCD, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
		add_op(igl_pkg::FUNC_XGCD, -32'sd240, 32'd46);
		add_op(igl_pkg::FUNC_XGCD, 32'd240, -32'sd46);
		add_op(igl_pkg::FUNC_XGCD, 32'd1836311903, 32'd1134903170);
		add_op(igl_pkg::FUNC_XGCD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		add_op(igl_pkg::FUNC_XGCD, 32'h8000_0001, 32'h7FFF_FFFF);
		add_op(FUNC_RSVD, 32'hFFFF_FFFF, 32'h0);
		add_op(FUNC_RSVD, 32'h0, 32'hFFFF_FFFF);
		wait_drained();

		// sender pauses between chunks until every result is back
		for (int chunk = 0; chunk < 3; chunk++) begin
			repeat (CHUNK_ITEMS) add_random_op();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			error_count += expected_results.size();
			$display("%0d expected results never arrived", expected_results.size());
		end
		if (mismatch_count == 0 && error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
